[design/rkfrf_pkg.sv]
// Package: types, frame constants and key ROMs of the remote key frame repeat filter.
package rkfrf_pkg;

    localparam logic [7:0] START_REMOTE  = 8'h63;
    localparam logic [7:0] START_PANEL   = 8'h51;
    localparam logic [7:0] START_STANDBY = 8'h80;

    localparam logic [2:0] LAST_REMOTE  = 3'd4;
    localparam logic [2:0] LAST_PANEL   = 3'd2;
    localparam logic [2:0] LAST_STANDBY = 3'd1;
    localparam logic [2:0] KEY_POS_REMOTE = 3'd3;
    localparam logic [2:0] KEY_POS_PANEL  = 3'd1;

    localparam logic [10:0] UNKNOWN_KEY = 11'h7FF;

    localparam logic [7:0]  MAX_RATE_RESET  = 8'd3;
    localparam logic [15:0] MAX_DELAY_RESET = 16'd150;
    localparam logic [7:0]  RATE_SAT        = 8'd255;

    localparam logic [7:0] REG_MAX_RATE  = 8'd0;
    localparam logic [7:0] REG_MAX_DELAY = 8'd1;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    typedef enum logic [1:0] {
        FK_REMOTE,
        FK_PANEL,
        FK_STANDBY
    } frame_kind_t;

    // Decoded frame handed from the assembler to the repeat filter
    typedef struct packed {
        logic [10:0] code;
        logic        panel;
        logic [31:0] stamp;
    } frame_evt_t;

    // Result item
    typedef struct packed {
        logic [9:0] key_code;
        logic       from_panel;
    } key_evt_t;

    function automatic logic [9:0] remote_rom(input logic [6:0] b);
        logic [9:0] r;
        case (b)
            7'h00: r = 10'd103;
            7'h01: r = 10'd108;
            7'h02: r = 10'd106;
            7'h03: r = 10'd105;
            7'h04: r = 10'd139;
            7'h06: r = 10'd138;
            7'h07: r = 10'd119;
            7'h08: r = 10'd365;
            7'h0A: r = 10'd116;
            7'h0C: r = 10'd113;
            7'h0D: r = 10'd388;
            7'h10: r = 10'd11;
            7'h11: r = 10'd2;
            7'h12: r = 10'd3;
            7'h13: r = 10'd4;
            7'h14: r = 10'd5;
            7'h15: r = 10'd6;
            7'h16: r = 10'd7;
            7'h17: r = 10'd8;
            7'h18: r = 10'd9;
            7'h19: r = 10'd10;
            7'h1C: r = 10'd102;
            7'h1F: r = 10'd352;
            7'h48: r = 10'd401;
            7'h49: r = 10'd400;
            7'h4A: r = 10'd399;
            7'h4B: r = 10'd398;
            7'h4E: r = 10'd115;
            7'h4F: r = 10'd114;
            7'h54: r = 10'd128;
            7'h55: r = 10'd207;
            7'h56: r = 10'd167;
            7'h58: r = 10'd168;
            7'h5C: r = 10'd208;
            7'h5E: r = 10'd104;
            7'h5F: r = 10'd109;
            default: r = 10'd0;
        endcase
        return r;
    endfunction

    function automatic logic [9:0] panel_rom(input logic [7:0] b);
        logic [9:0] r;
        case (b)
            8'h01: r = 10'd104;
            8'h02: r = 10'd109;
            8'h03: r = 10'd114;
            8'h04: r = 10'd115;
            default: r = 10'd0;
        endcase
        return r;
    endfunction

endpackage

[design/rkfrf_fifo.sv]
// Module: small register queue with simultaneous push and pop.
module rkfrf_fifo #(
    parameter int DEPTH = rkfrf_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int WIDTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push without pop did not grow the queue");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> wr_ptr_reg == rd_ptr_reg)
        else $error("empty queue with pointers apart");
endmodule

[design/rkfrf_front.sv]
// Module: frame assembler and key ROM lookup.
module rkfrf_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    input  logic [7:0]             rx_byte,
    input  logic [31:0]            now_ms,
    output logic                   evt_push,
    output rkfrf_pkg::frame_evt_t  evt
);
    rkfrf_pkg::frame_kind_t kind_reg, kind_next;
    logic [2:0]             cnt_reg, cnt_next;
    logic [7:0]             key_reg, key_next;
    logic [2:0]             last_idx;
    logic [9:0]             rom_code;

    always_comb
    begin
        case (kind_reg)
            rkfrf_pkg::FK_REMOTE:  last_idx = rkfrf_pkg::LAST_REMOTE;
            rkfrf_pkg::FK_PANEL:   last_idx = rkfrf_pkg::LAST_PANEL;
            rkfrf_pkg::FK_STANDBY: last_idx = rkfrf_pkg::LAST_STANDBY;
            default:               last_idx = rkfrf_pkg::LAST_STANDBY;
        endcase
    end

    // Look up from the held key byte; mask bit 7 of the remote key
    assign rom_code = (kind_reg == rkfrf_pkg::FK_PANEL) ? rkfrf_pkg::panel_rom(key_reg)
                                                        : rkfrf_pkg::remote_rom(key_reg[6:0]);

    always_comb
    begin
        kind_next = kind_reg;
        cnt_next  = cnt_reg;
        key_next  = key_reg;
        evt_push  = 1'b0;
        evt.code  = (rom_code == '0) ? rkfrf_pkg::UNKNOWN_KEY : {1'b0, rom_code};
        evt.panel = (kind_reg == rkfrf_pkg::FK_PANEL);
        evt.stamp = now_ms;
        if (byte_valid)
        begin
            if (cnt_reg == '0)
            begin
                cnt_next = 3'd1;
                case (rx_byte)
                    rkfrf_pkg::START_REMOTE:  kind_next = rkfrf_pkg::FK_REMOTE;
                    rkfrf_pkg::START_PANEL:   kind_next = rkfrf_pkg::FK_PANEL;
                    rkfrf_pkg::START_STANDBY: kind_next = rkfrf_pkg::FK_STANDBY;
                    default:                  cnt_next  = '0;
                endcase
            end
            else
            begin
                if ((kind_reg == rkfrf_pkg::FK_PANEL && cnt_reg == rkfrf_pkg::KEY_POS_PANEL) ||
                    (kind_reg == rkfrf_pkg::FK_REMOTE && cnt_reg == rkfrf_pkg::KEY_POS_REMOTE))
                begin
                    key_next = rx_byte;
                end
                if (cnt_reg == last_idx)
                begin
                    cnt_next = '0;
                    evt_push = (kind_reg != rkfrf_pkg::FK_STANDBY);
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= rkfrf_pkg::FK_STANDBY;
            cnt_reg  <= '0;
        end
        else
        begin
            kind_reg <= kind_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= rkfrf_pkg::LAST_REMOTE)
        else $error("frame byte count out of range");

    a_push_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        evt_push |=> cnt_reg == '0)
        else $error("frame handed on without closing");

    a_no_standby_push: assert property (@(posedge clk) disable iff (!rst_n)
        evt_push |-> kind_reg != rkfrf_pkg::FK_STANDBY)
        else $error("standby frame handed on");
endmodule

[design/rkfrf_back.sv]
// Module: repeat filter with its configuration registers.
module rkfrf_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [7:0]             cfg_index,
    input  logic [15:0]            cfg_data,
    input  logic                   evt_valid,
    input  rkfrf_pkg::frame_evt_t  evt,
    output logic                   evt_pop,
    input  logic                   res_full,
    output logic                   res_push,
    output rkfrf_pkg::key_evt_t    res
);
    logic [7:0]  max_rate_reg;
    logic [15:0] max_delay_reg;
    logic [10:0] last_key_reg;
    logic [31:0] last_stamp_reg;
    logic [7:0]  repeat_reg, repeat_next;
    logic [31:0] gap;
    logic [7:0]  repeat_sat;
    logic        is_new, pass;

    assign evt_pop    = evt_valid && !res_full;
    assign gap        = evt.stamp - last_stamp_reg;
    // A zero stamp counts as no gap
    assign is_new     = (evt.code != last_key_reg) ||
                        ((last_stamp_reg != '0) && (gap > {16'd0, max_delay_reg}));
    assign repeat_sat = (repeat_reg == rkfrf_pkg::RATE_SAT) ? repeat_reg : repeat_reg + 1'b1;
    assign pass       = is_new || (repeat_sat >= max_rate_reg);
    assign repeat_next = pass ? '0 : repeat_sat;

    assign res_push       = evt_pop && pass && (evt.code != rkfrf_pkg::UNKNOWN_KEY);
    assign res.key_code   = evt.code[9:0];
    assign res.from_panel = evt.panel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_rate_reg   <= rkfrf_pkg::MAX_RATE_RESET;
            max_delay_reg  <= rkfrf_pkg::MAX_DELAY_RESET;
            last_key_reg   <= '0;
            last_stamp_reg <= '0;
            repeat_reg     <= '0;
        end
        else
        begin
            if (cfg_write && cfg_index == rkfrf_pkg::REG_MAX_RATE)
            begin
                max_rate_reg <= cfg_data[7:0];
            end
            if (cfg_write && cfg_index == rkfrf_pkg::REG_MAX_DELAY)
            begin
                max_delay_reg <= cfg_data;
            end
            if (evt_pop)
            begin
                last_key_reg   <= evt.code;
                last_stamp_reg <= evt.stamp;
                repeat_reg     <= repeat_next;
            end
        end
    end

    a_push_needs_pop: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> evt_pop && !res_full)
        else $error("result pushed without a frame taken");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> repeat_reg == '0)
        else $error("repeat count not cleared after a key");

    a_unknown_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_pop && evt.code == rkfrf_pkg::UNKNOWN_KEY) |-> !res_push)
        else $error("unknown key emitted");

    a_key_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        evt_pop |=> last_key_reg == $past(evt.code))
        else $error("last key not updated");
endmodule

[design/remote_key_frame_repeat_filter.sv]
// Top level: remote key frame decoder with repeat filter.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------
//  input   | push / full          | rx_byte[7:0], now_ms[31:0]
//  result  | empty / pop          | key_code[9:0], from_panel
//  config  | cfg_valid / cfg_ready| cfg_index[7:0], cfg_data[15:0]
//
//  One byte is accepted every cycle while full is low; the assembler never
//  stalls on its own. Completed frames queue up ahead of the filter.
//  full rises only when the frame queue is full, which happens when results
//  are not popped and the result queue has backed up behind it.
//  cfg_ready is always high; a write with an index beyond 1 is ignored.
//  rst_n clears the assembler, filter state and both queues at once.
module remote_key_frame_repeat_filter #(
    parameter int QUEUE_DEPTH = rkfrf_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    input  logic [31:0] now_ms,
    output logic        empty,
    input  logic        pop,
    output logic [9:0]  key_code,
    output logic        from_panel,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int EVT_W = $bits(rkfrf_pkg::frame_evt_t);
    localparam int RES_W = $bits(rkfrf_pkg::key_evt_t);

    logic                  byte_valid;
    logic                  fq_push, fq_pop, fq_empty;
    rkfrf_pkg::frame_evt_t fq_in, fq_out;
    logic                  rq_push, rq_full;
    rkfrf_pkg::key_evt_t   rq_in, rq_out;

    // Take a byte whenever the frame queue has room
    assign byte_valid = push && !full;
    assign cfg_ready  = 1'b1;

    rkfrf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .rx_byte    (rx_byte),
        .now_ms     (now_ms),
        .evt_push   (fq_push),
        .evt        (fq_in)
    );

    // Decoded frames wait here so the assembler and filter stall apart
    rkfrf_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (EVT_W)
    ) u_frame_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fq_push),
        .wr_data (fq_in),
        .full    (full),
        .pop     (fq_pop),
        .rd_data (fq_out),
        .empty   (fq_empty)
    );

    rkfrf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .evt_valid (!fq_empty),
        .evt       (fq_out),
        .evt_pop   (fq_pop),
        .res_full  (rq_full),
        .res_push  (rq_push),
        .res       (rq_in)
    );

    // Hold emitted keys until the consumer pops them
    rkfrf_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (RES_W)
    ) u_result_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (rq_push),
        .wr_data (rq_in),
        .full    (rq_full),
        .pop     (pop),
        .rd_data (rq_out),
        .empty   (empty)
    );

    assign key_code   = rq_out.key_code;
    assign from_panel = rq_out.from_panel;
endmodule

[tb/rkfrf_key_checker.sv]
// Checker: follows the byte and key channels, predicts the key items and compares them.
`timescale 1ns / 100ps

module rkfrf_key_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  rx_byte,
    input  logic [31:0] now_ms,
    input  logic        empty,
    input  logic        pop,
    input  logic [9:0]  key_code,
    input  logic        from_panel,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    logic [7:0]            rate_limit;
    logic [15:0]           delay_limit;
    logic [7:0]            frame_buf [5];
    logic [2:0]            held;
    logic [10:0]           prev_code;
    logic [31:0]           prev_stamp;
    logic [7:0]            repeats;
    rkfrf_pkg::key_evt_t   expected_keys [$];
    int                    mismatches = 0;

    assign fail_count = mismatches;

    function automatic logic [2:0] frame_len(input logic [7:0] first);
        if (first == rkfrf_pkg::START_REMOTE)
            return 3'd5;
        if (first == rkfrf_pkg::START_PANEL)
            return 3'd3;
        if (first == rkfrf_pkg::START_STANDBY)
            return 3'd2;
        return 3'd0;
    endfunction

    function automatic logic [9:0] remote_key(input logic [6:0] b);
        case (b)
            7'h00: return 10'd103;
            7'h01: return 10'd108;
            7'h02: return 10'd106;
            7'h03: return 10'd105;
            7'h04: return 10'd139;
            7'h06: return 10'd138;
            7'h07: return 10'd119;
            7'h08: return 10'd365;
            7'h0A: return 10'd116;
            7'h0C: return 10'd113;
            7'h0D: return 10'd388;
            7'h10: return 10'd11;
            7'h11: return 10'd2;
            7'h12: return 10'd3;
            7'h13: return 10'd4;
            7'h14: return 10'd5;
            7'h15: return 10'd6;
            7'h16: return 10'd7;
            7'h17: return 10'd8;
            7'h18: return 10'd9;
            7'h19: return 10'd10;
            7'h1C: return 10'd102;
            7'h1F: return 10'd352;
            7'h48: return 10'd401;
            7'h49: return 10'd400;
            7'h4A: return 10'd399;
            7'h4B: return 10'd398;
            7'h4E: return 10'd115;
            7'h4F: return 10'd114;
            7'h54: return 10'd128;
            7'h55: return 10'd207;
            7'h56: return 10'd167;
            7'h58: return 10'd168;
            7'h5C: return 10'd208;
            7'h5E: return 10'd104;
            7'h5F: return 10'd109;
            default: return 10'd0;
        endcase
    endfunction

    function automatic logic [9:0] panel_key(input logic [7:0] b);
        case (b)
            8'h01: return 10'd104;
            8'h02: return 10'd109;
            8'h03: return 10'd114;
            8'h04: return 10'd115;
            default: return 10'd0;
        endcase
    endfunction

    task automatic report(input string what, input int unsigned got, input int unsigned want);
        $display("%0t ns: %s is %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Advance the frame assembler and repeat filter by one byte
    task automatic decode_byte(input logic [7:0] b, input logic [31:0] stamp);
        logic                panel;
        logic                fresh;
        logic                emit;
        logic [9:0]          rom;
        logic [10:0]         code;
        rkfrf_pkg::key_evt_t item;
        if (held == 3'd0)
        begin
            if (frame_len(b) != 3'd0)
            begin
                frame_buf[0] = b;
                held = 3'd1;
            end
        end
        else if (held >= 3'd5 || frame_len(frame_buf[0]) == 3'd0)
        begin
            held = 3'd0;
        end
        else
        begin
            frame_buf[held] = b;
            held = held + 3'd1;
            if (held == frame_len(frame_buf[0]))
            begin
                held = 3'd0;
                if (frame_buf[0] != rkfrf_pkg::START_STANDBY)
                begin
                    panel = (frame_buf[0] == rkfrf_pkg::START_PANEL);
                    rom = panel ? panel_key(frame_buf[1]) : remote_key(frame_buf[3][6:0]);
                    code = (rom == 10'd0) ? rkfrf_pkg::UNKNOWN_KEY : {1'b0, rom};
                    fresh = (code != prev_code);
                    if (!fresh)
                    begin
                        if (prev_stamp == 32'd0)
                            prev_stamp = stamp;
                        fresh = (stamp - prev_stamp) > {16'd0, delay_limit};
                    end
                    prev_code = code;
                    prev_stamp = stamp;
                    emit = 1'b1;
                    if (fresh)
                    begin
                        repeats = 8'd0;
                    end
                    else
                    begin
                        if (repeats != rkfrf_pkg::RATE_SAT)
                            repeats = repeats + 8'd1;
                        if (repeats < rate_limit)
                            emit = 1'b0;
                    end
                    if (emit)
                    begin
                        repeats = 8'd0;
                        if (code != rkfrf_pkg::UNKNOWN_KEY)
                        begin
                            item.key_code = code[9:0];
                            item.from_panel = panel;
                            expected_keys.push_back(item);
                        end
                    end
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        rkfrf_pkg::key_evt_t want;
        if (!rst_n)
        begin
            rate_limit = rkfrf_pkg::MAX_RATE_RESET;
            delay_limit = rkfrf_pkg::MAX_DELAY_RESET;
            held = 3'd0;
            prev_code = 11'd0;
            prev_stamp = 32'd0;
            repeats = 8'd0;
            expected_keys.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == rkfrf_pkg::REG_MAX_RATE)
                    rate_limit = cfg_data[7:0];
                else if (cfg_index == rkfrf_pkg::REG_MAX_DELAY)
                    delay_limit = cfg_data;
            end
            if (pop && !empty)
            begin
                if (expected_keys.size() == 0)
                begin
                    report("key_code of an item with none expected", 32'(key_code), 32'd0);
                end
                else
                begin
                    want = expected_keys.pop_front();
                    if (key_code !== want.key_code)
                        report("key_code", 32'(key_code), 32'(want.key_code));
                    if (from_panel !== want.from_panel)
                        report("from_panel", 32'(from_panel), 32'(want.from_panel));
                end
            end
            if (push && !full)
                decode_byte(rx_byte, now_ms);
            pending <= expected_keys.size();
        end
    end

endmodule

[tb/tb_remote_key_frame_repeat_filter.sv]
// Testbench top: drives byte frames and register writes into the key repeat filter.
`timescale 1ns / 100ps

module tb_remote_key_frame_repeat_filter;

    // Indexes above the last register; writes there must change nothing
    localparam logic [7:0] REG_BEYOND = rkfrf_pkg::REG_MAX_DELAY + 8'd1;
    localparam logic [7:0] REG_TOP    = 8'hFF;
    // Bound on the wait for outstanding key items at a drain
    localparam int unsigned DRAIN_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  rx_byte = 8'd0;
    logic [31:0] now_ms = 32'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic [9:0]  key_code;
    logic        from_panel;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = 8'd0;
    logic [15:0] cfg_data = 16'd0;

    int          fail_count;
    int          pending;

    // Stimulus knobs: idle and stall rates are percentages of cycles
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned cur_delay = 150;
    int unsigned bytes_sent = 0;
    logic [31:0] clock_ms = 32'd0;
    // Last freshly picked frame key, replayed to build runs of held keys
    logic        held_panel = 1'b0;
    logic [7:0]  held_key = 8'd0;
    bit          have_held = 1'b0;

    always #5 clk = ~clk;

    remote_key_frame_repeat_filter u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .rx_byte    (rx_byte),
        .now_ms     (now_ms),
        .empty      (empty),
        .pop        (pop),
        .key_code   (key_code),
        .from_panel (from_panel),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    rkfrf_key_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .rx_byte    (rx_byte),
        .now_ms     (now_ms),
        .empty      (empty),
        .pop        (pop),
        .key_code   (key_code),
        .from_panel (from_panel),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Receiver side: pop at random, held back for stall_pct of the cycles
    always @(posedge clk)
        pop <= rst_n && ($urandom_range(99, 0) >= stall_pct);

    // Offer one byte, idling first as the current phase asks, and hold it until taken
    task automatic put_byte(input logic [7:0] b, input logic [31:0] stamp);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        rx_byte <= b;
        now_ms <= stamp;
        @(posedge clk);
        while (full)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Stop sending and wait until every expected key item has been popped,
    // then let the last byte's frame clear the filter
    task automatic drain();
        int unsigned waited;
        push <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    // Raise a register write and hold it until accepted; the caller lowers valid
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // One random unit of traffic: mostly well-formed frames, some noise
    task automatic send_frame();
        int unsigned pick;
        int unsigned extra;
        logic [7:0]  kb;
        logic        as_panel;
        // Advance the time so that gaps land on both sides of max_delay
        pick = $urandom_range(99, 0);
        if (pick < 10)
            clock_ms = clock_ms;
        else if (pick < 55)
            clock_ms = clock_ms + $urandom_range(cur_delay, 1);
        else if (pick < 70)
            clock_ms = clock_ms + cur_delay + $urandom_range(1, 0);
        else if (pick < 90)
            clock_ms = clock_ms + $urandom_range(2 * cur_delay + 10, cur_delay);
        else
            clock_ms = clock_ms + $urandom;

        pick = $urandom_range(99, 0);
        if (pick < 12)
        begin
            // stray byte, which may well open a frame of its own
            put_byte(8'($urandom), clock_ms);
        end
        else if (pick < 20)
        begin
            put_byte(rkfrf_pkg::START_STANDBY, clock_ms);
            put_byte(8'($urandom), clock_ms);
        end
        else if (pick < 26)
        begin
            // cut-short frame: whatever follows fills its tail
            put_byte(($urandom_range(1, 0) != 0) ? rkfrf_pkg::START_REMOTE
                                                 : rkfrf_pkg::START_PANEL, clock_ms);
            extra = $urandom_range(2, 0);
            repeat (extra) put_byte(8'($urandom), clock_ms);
        end
        else
        begin
            if (have_held && $urandom_range(99, 0) < 50)
            begin
                as_panel = held_panel;
                kb = held_key;
            end
            else
            begin
                as_panel = 1'($urandom_range(1, 0));
                kb = 8'($urandom);
                if (as_panel)
                begin
                    if ($urandom_range(99, 0) < 75)
                        kb = 8'($urandom_range(4, 1));
                end
                else if ($urandom_range(99, 0) < 85)
                begin
                    // aim at the two populated stretches of the remote table
                    kb[6:0] = ($urandom_range(1, 0) != 0) ? 7'($urandom_range(8'h1F, 8'h00))
                                                          : 7'($urandom_range(8'h5F, 8'h48));
                end
                held_panel = as_panel;
                held_key = kb;
                have_held = 1'b1;
            end
            if (as_panel)
            begin
                put_byte(rkfrf_pkg::START_PANEL, clock_ms);
                put_byte(kb, clock_ms);
                put_byte(8'($urandom), clock_ms);
            end
            else
            begin
                put_byte(rkfrf_pkg::START_REMOTE, clock_ms);
                put_byte(8'($urandom), clock_ms);
                put_byte(8'($urandom), clock_ms);
                put_byte(kb, clock_ms);
                put_byte(8'($urandom), clock_ms);
            end
        end
    endtask

    // Drain, write junk indexes if asked, program both limits, set the idling mix,
    // then send: first a run of one held panel key, then random traffic with an optional mid-phase drain
    task automatic run_phase(input logic [7:0] rate, input logic [15:0] delay,
                             input int unsigned s_idle, input int unsigned r_stall,
                             input int unsigned streak, input int unsigned budget,
                             input bit junk_writes, input bit mid_drain);
        int unsigned start;
        drain();
        if (junk_writes)
        begin
            write_reg(REG_TOP, 16'($urandom));
            write_reg(8'($urandom_range(REG_TOP, REG_BEYOND)), 16'($urandom));
        end
        // upper data bits of the rate write are don't-care
        write_reg(rkfrf_pkg::REG_MAX_RATE, {8'($urandom), rate});
        write_reg(rkfrf_pkg::REG_MAX_DELAY, delay);
        cfg_valid <= 1'b0;
        send_idle_pct = s_idle;
        stall_pct <= r_stall;
        cur_delay = 32'(delay);
        repeat (streak)
        begin
            clock_ms = clock_ms + $urandom_range(200, 0);
            put_byte(rkfrf_pkg::START_PANEL, clock_ms);
            put_byte(8'h02, clock_ms);
            put_byte(8'($urandom), clock_ms);
        end
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            send_frame();
            // hold off once mid-phase until the output side has caught up
            if (mid_drain && bytes_sent - start >= budget / 2)
            begin
                drain();
                mid_drain = 1'b0;
            end
        end
    endtask

    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, at the reset limits (rate 3, delay 150)
        put_byte(8'hFF, 32'd0);                 // stray byte, dropped
        put_byte(rkfrf_pkg::START_STANDBY, 32'd0);         // standby frame, discarded
        put_byte(8'h00, 32'd0);
        put_byte(rkfrf_pkg::START_PANEL, 32'd0);           // panel key 104, new against reset code
        put_byte(8'h01, 32'd0);
        put_byte(8'h00, 32'd0);
        put_byte(rkfrf_pkg::START_PANEL, 32'd5);           // same code with a zero last stamp
        put_byte(8'h01, 32'd5);
        put_byte(8'hFF, 32'd5);
        put_byte(rkfrf_pkg::START_REMOTE, 32'hFFFF_FFF0);  // remote 104 with bit 7 set, long gap
        put_byte(8'hFF, 32'hFFFF_FFF0);
        put_byte(8'h00, 32'hFFFF_FFF0);
        put_byte(8'hDE, 32'hFFFF_FFF0);
        put_byte(8'h00, 32'hFFFF_FFF0);
        put_byte(rkfrf_pkg::START_PANEL, 32'h0000_0010);   // time wraps: short gap, repeat
        put_byte(8'h01, 32'h0000_0010);
        put_byte(8'h7F, 32'h0000_0010);
        put_byte(rkfrf_pkg::START_REMOTE, 32'h0000_0020);  // unknown remote key byte
        put_byte(8'h00, 32'h0000_0020);
        put_byte(8'h00, 32'h0000_0020);
        put_byte(8'h05, 32'h0000_0020);
        put_byte(8'h00, 32'h0000_0020);
        put_byte(rkfrf_pkg::START_PANEL, 32'h0000_0030);   // panel key 115
        put_byte(8'h04, 32'h0000_0030);
        put_byte(8'h00, 32'h0000_0030);
        clock_ms = 32'h0000_0030;

        // Random part, one phase per register setting and idling mix
        run_phase(rkfrf_pkg::MAX_RATE_RESET, rkfrf_pkg::MAX_DELAY_RESET,
                  0, 0, 0, 55, 1'b0, 1'b0);
        run_phase(8'd0, 16'd0, 58, 0, 0, 55, 1'b0, 1'b0);
        run_phase(8'd255, 16'hFFFF, 0, 58, 258, 40, 1'b0, 1'b0);
        run_phase(8'd1, 16'd20, 16, 16, 0, 55, 1'b0, 1'b0);
        run_phase(8'($urandom_range(6, 2)), 16'($urandom_range(300, 0)),
                  0, 0, 0, 55, 1'b1, 1'b1);

        drain();
        if (fail_count == 0 && pending == 0)
            $display("PASS remote_key_frame_repeat_filter");
        else
            $display("FAIL remote_key_frame_repeat_filter");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin : watchdog
        #3_000_000;
        $display("FAIL remote_key_frame_repeat_filter");
        $finish;
    end

endmodule

[sim.f]
design/rkfrf_pkg.sv
design/rkfrf_fifo.sv
design/rkfrf_front.sv
design/rkfrf_back.sv
design/remote_key_frame_repeat_filter.sv
tb/rkfrf_key_checker.sv
tb/tb_remote_key_frame_repeat_filter.sv
